>>> design/lac_pkg.sv
// Shared types, codes and arithmetic helpers for the Lab alpha compositor.
`timescale 1ns / 1ps

package lac_pkg;

    typedef struct packed {
        logic [15:0] lightness;
        logic [15:0] chroma_a;
        logic [15:0] chroma_b;
        logic [15:0] alpha;
    } t_pix;

    typedef struct packed {
        logic [1:0] blend_mode;
        logic [7:0] layer_opacity;
        logic       mask_enable;
    } t_cfg;

    // Per-item decisions taken along the pipeline
    typedef struct packed {
        logic pass;        // masked source alpha is zero: keep destination
        logic copy;        // scaled source alpha is opaque: take source
        logic dst_opaque;  // destination alpha is opaque: alpha stays
        logic sat;         // blend factor quotient overflows 16 bits
    } t_ctl;

    typedef struct packed {
        t_pix        src;
        t_pix        dst;
        logic [15:0] sa;   // scaled source alpha (erase: resulting alpha)
        logic [15:0] na;   // union alpha
        t_ctl        ctl;
    } t_item;

    localparam logic [1:0] MODE_PASS  = 2'd0;
    localparam logic [1:0] MODE_OVER  = 2'd1;
    localparam logic [1:0] MODE_ERASE = 2'd2;

    localparam logic [1:0] REG_BLEND_MODE    = 2'd0;
    localparam logic [1:0] REG_LAYER_OPACITY = 2'd1;
    localparam logic [1:0] REG_MASK_ENABLE   = 2'd2;

    localparam logic [1:0]  RST_BLEND_MODE    = MODE_OVER;
    localparam logic [7:0]  RST_LAYER_OPACITY = 8'hFF;
    localparam logic        RST_MASK_ENABLE   = 1'b0;

    localparam logic [15:0] ALPHA_MAX = 16'hFFFF;
    localparam logic [7:0]  MASK_FULL = 8'hFF;

    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = 4;

    // Rounded 16x16 fixed-point product: t = p + 2^15, (t + t>>16) >> 16
    function automatic logic [15:0] mul_round(input logic [31:0] prod);
        logic [32:0] t;
        logic [33:0] s;
        t = {1'b0, prod} + 33'd32768;
        s = {1'b0, t} + {17'h0, t[32:16]};
        return s[31:16];
    endfunction

endpackage

>>> design/lac_alpha.sv
// Alpha path: mask and opacity scaling, erase alpha and union alpha, four stages.
`timescale 1ns / 1ps

module lac_alpha (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lac_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    output logic          o_ready,
    input  lac_pkg::t_pix i_src,
    input  lac_pkg::t_pix i_dst,
    input  logic [7:0]    i_mask,
    output logic          o_valid,
    input  logic          i_ready,
    output lac_pkg::t_item o_item
);

    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;

    lac_pkg::t_pix r1_src, r1_dst, r2_src, r2_dst, r3_src, r3_dst;
    logic          r1_mact;
    logic [31:0]   r1_prod, r2_prod, r3_prod;
    logic [15:0]   r2_sa1, r3_sa;
    logic          r3_pass;
    lac_pkg::t_item r4_item;

    logic          is_erase;
    logic [15:0]   opac;
    logic          n1_mact;
    logic [15:0]   n1_opnd;
    logic [31:0]   n1_prod;
    logic [32:0]   n2_ceil;
    logic [15:0]   n2_erase_sa, n2_sa1, n2_opb;
    logic [31:0]   n2_prod;
    logic [15:0]   n3_sa_over, n3_sa, n3_inv_da;
    logic [31:0]   n3_prod;
    lac_pkg::t_item n4_item;

    assign is_erase = (i_cfg.blend_mode == lac_pkg::MODE_ERASE);
    assign opac     = {i_cfg.layer_opacity, i_cfg.layer_opacity};

    assign en4     = !r_v4 || i_ready;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v4;
    assign o_item  = r4_item;

    // Stage 1: mask multiply (erase works on the complement of source alpha)
    assign n1_mact = i_cfg.mask_enable && (i_mask != lac_pkg::MASK_FULL);
    assign n1_opnd = is_erase ? ~i_src.alpha : i_src.alpha;
    assign n1_prod = n1_opnd * {i_mask, i_mask};

    // Stage 2: finish mask step, multiply by opacity or destination alpha
    assign n2_ceil     = {1'b0, r1_prod} + 33'h0_FFFF;
    assign n2_erase_sa = lac_pkg::ALPHA_MAX - n2_ceil[31:16];
    assign n2_sa1      = !r1_mact ? r1_src.alpha
                       : (is_erase ? n2_erase_sa : lac_pkg::mul_round(r1_prod));
    assign n2_opb      = is_erase ? r1_dst.alpha : opac;
    assign n2_prod     = n2_sa1 * n2_opb;

    // Stage 3: finish opacity step, start union alpha
    assign n3_sa_over = (opac != lac_pkg::ALPHA_MAX) ? lac_pkg::mul_round(r2_prod) : r2_sa1;
    assign n3_sa      = is_erase ? lac_pkg::mul_round(r2_prod) : n3_sa_over;
    assign n3_inv_da  = ~r2_dst.alpha;
    assign n3_prod    = n3_inv_da * n3_sa_over;

    // Stage 4: union alpha and decision flags
    always_comb begin
        n4_item                = '0;
        n4_item.src            = r3_src;
        n4_item.dst            = r3_dst;
        n4_item.sa             = r3_sa;
        n4_item.na             = r3_dst.alpha + lac_pkg::mul_round(r3_prod);
        n4_item.ctl.pass       = r3_pass;
        n4_item.ctl.copy       = (r3_sa == lac_pkg::ALPHA_MAX);
        n4_item.ctl.dst_opaque = (r3_dst.alpha == lac_pkg::ALPHA_MAX);
        n4_item.ctl.sat        = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_src  <= i_src;
            r1_dst  <= i_dst;
            r1_mact <= n1_mact;
            r1_prod <= n1_prod;
        end
        if (en2) begin
            r2_src  <= r1_src;
            r2_dst  <= r1_dst;
            r2_sa1  <= n2_sa1;
            r2_prod <= n2_prod;
        end
        if (en3) begin
            r3_src  <= r2_src;
            r3_dst  <= r2_dst;
            r3_sa   <= n3_sa;
            r3_pass <= (r2_sa1 == 16'h0000);
            r3_prod <= n3_prod;
        end
        if (en4) begin
            r4_item <= n4_item;
        end
    end

endmodule

>>> design/lac_div.sv
// Pipelined restoring divider for the blend factor, a few quotient bits per stage.
`timescale 1ns / 1ps

module lac_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  lac_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output lac_pkg::t_item o_item,
    output logic [15:0]    o_quo
);

    localparam int NS = lac_pkg::DIV_STAGES;

    logic           w_valid [0:NS];
    logic           w_en    [0:NS];
    lac_pkg::t_item w_item  [0:NS];
    logic [15:0]    w_rem   [0:NS];
    logic [15:0]    w_low   [0:NS];
    logic [15:0]    w_quo   [0:NS];

    logic           r0_valid;
    lac_pkg::t_item r0_item;
    logic [15:0]    r0_rem, r0_low;
    logic [32:0]    n0_num;
    logic           n0_sat;
    lac_pkg::t_item n0_item;

    // Stage 0: dividend sa*65535 + na/2, overflow check against na << 16
    assign n0_num = {1'b0, i_item.sa, 16'h0000} - {17'h0, i_item.sa}
                  + {18'h0, i_item.na[15:1]};
    assign n0_sat = (n0_num >= {1'b0, i_item.na, 16'h0000});

    always_comb begin
        n0_item         = i_item;
        n0_item.ctl.sat = n0_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (w_en[0]) begin
            r0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r0_item <= n0_item;
            r0_rem  <= n0_num[31:16];
            r0_low  <= n0_num[15:0];
        end
    end

    assign w_valid[0] = r0_valid;
    assign w_item[0]  = r0_item;
    assign w_rem[0]   = r0_rem;
    assign w_low[0]   = r0_low;
    assign w_quo[0]   = 16'h0000;
    assign w_en[NS]   = !w_valid[NS] || i_ready;

    genvar k;
    generate
        for (k = 0; k < NS; k = k + 1) begin : g_stage
            logic           r_valid;
            lac_pkg::t_item r_item;
            logic [15:0]    r_rem, r_low, r_quo;
            logic [15:0]    n_rem, n_low, n_quo;

            assign w_en[k] = !w_valid[k] || w_en[k+1];

            // Shift in one dividend bit per step, subtract where it fits
            always_comb begin
                logic [16:0] v_trial;
                n_rem = w_rem[k];
                n_low = w_low[k];
                n_quo = w_quo[k];
                for (int j = 0; j < lac_pkg::DIV_BITS; j++) begin
                    v_trial = {n_rem, n_low[15]};
                    n_low   = {n_low[14:0], 1'b0};
                    if (v_trial >= {1'b0, w_item[k].na}) begin
                        v_trial = v_trial - {1'b0, w_item[k].na};
                        n_quo   = {n_quo[14:0], 1'b1};
                    end else begin
                        n_quo   = {n_quo[14:0], 1'b0};
                    end
                    n_rem = v_trial[15:0];
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid <= 1'b0;
                end else if (w_en[k+1]) begin
                    r_valid <= w_valid[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_en[k+1]) begin
                    r_item <= w_item[k];
                    r_rem  <= n_rem;
                    r_low  <= n_low;
                    r_quo  <= n_quo;
                end
            end

            assign w_valid[k+1] = r_valid;
            assign w_item[k+1]  = r_item;
            assign w_rem[k+1]   = r_rem;
            assign w_low[k+1]   = r_low;
            assign w_quo[k+1]   = r_quo;
        end
    endgenerate

    assign o_ready = w_en[0];
    assign o_valid = w_valid[NS];
    assign o_item  = w_item[NS];
    assign o_quo   = w_quo[NS];

    a_rem_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r0_valid && !r0_item.ctl.sat && r0_item.na != 16'h0000) |-> (r0_rem < r0_item.na))
        else $error("divider start remainder not below divisor");

    a_rem_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[NS] && !w_item[NS].ctl.sat && w_item[NS].na != 16'h0000)
        |-> (w_rem[NS] < w_item[NS].na))
        else $error("divider final remainder not below divisor");

endmodule

>>> design/lac_blend.sv
// Blend factor select, L/a/b interpolation and result selection, two stages.
`timescale 1ns / 1ps

module lac_blend (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lac_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    output logic           o_ready,
    input  lac_pkg::t_item i_item,
    input  logic [15:0]    i_quo,
    output logic           o_valid,
    input  logic           i_ready,
    output lac_pkg::t_pix  o_pix
);

    logic r_v1, r_v2;
    logic en1, en2;

    logic [15:0]        w_scol [3];
    logic [15:0]        w_dcol [3];
    logic [15:0]        r1_dcol [3];
    logic [15:0]        n_f;
    logic signed [33:0] n1_prod [3];
    logic signed [33:0] r1_prod [3];
    logic               r1_fcopy;
    lac_pkg::t_item     r1_item;
    logic [15:0]        n_mix [3];
    lac_pkg::t_pix      n2_pix, r2_pix;

    assign en2     = !r_v2 || i_ready;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v2;
    assign o_pix   = r2_pix;

    assign w_scol[0] = i_item.src.lightness;
    assign w_scol[1] = i_item.src.chroma_a;
    assign w_scol[2] = i_item.src.chroma_b;
    assign w_dcol[0] = i_item.dst.lightness;
    assign w_dcol[1] = i_item.dst.chroma_a;
    assign w_dcol[2] = i_item.dst.chroma_b;

    assign r1_dcol[0] = r1_item.dst.lightness;
    assign r1_dcol[1] = r1_item.dst.chroma_a;
    assign r1_dcol[2] = r1_item.dst.chroma_b;

    // Factor: source alpha if dst is opaque or na is zero, else the capped quotient
    assign n_f = (i_item.ctl.dst_opaque || i_item.na == 16'h0000) ? i_item.sa
               : (i_item.ctl.sat ? lac_pkg::ALPHA_MAX : i_quo);

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n1_prod[c] = $signed({1'b0, w_scol[c]} - {1'b0, w_dcol[c]})
                       * $signed({1'b0, n_f});
        end
    end

    // Arithmetic shift by 16 is the floor, so the upper half plus dst is the blend
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_mix[c] = r1_prod[c][31:16] + r1_dcol[c];
        end
        n2_pix = r1_item.dst;
        case (i_cfg.blend_mode)
            lac_pkg::MODE_OVER: begin
                if (!r1_item.ctl.pass) begin
                    if (r1_item.ctl.copy || r1_fcopy) begin
                        n2_pix = r1_item.src;
                    end else begin
                        n2_pix.lightness = n_mix[0];
                        n2_pix.chroma_a  = n_mix[1];
                        n2_pix.chroma_b  = n_mix[2];
                        n2_pix.alpha     = r1_item.ctl.dst_opaque ? r1_item.dst.alpha
                                                                  : r1_item.na;
                    end
                end
            end
            lac_pkg::MODE_ERASE: begin
                n2_pix.alpha = r1_item.sa;
            end
            default: begin
                n2_pix = r1_item.dst;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_prod  <= n1_prod;
            r1_fcopy <= (n_f == lac_pkg::ALPHA_MAX);
            r1_item  <= i_item;
        end
        if (en2) begin
            r2_pix <= n2_pix;
        end
    end

endmodule

>>> design/lab_alpha_compositor.sv
// Top level of the Lab alpha compositor: register port and pipeline chain.
`timescale 1ns / 1ps

// Composites one 16-bit L/a/b/alpha source pixel onto a destination pixel per item
// and returns the new destination pixel. It takes one item per clock while the
// output side keeps up; each item passes through four stages of alpha arithmetic
// (mask multiply, opacity multiply, union alpha), five stages of the blend factor
// divider (operand setup, then four quotient bits per stage) and two stages of color
// blending and result selection. Every stage holds its item on its own when the next
// one is full, so empty stages close up under a stall. Registers: blend_mode at 0x0
// (0 pass, 1 over, 2 erase), layer_opacity at 0x4, mask_enable at 0x8; write them
// only while no item is in flight.
module lab_alpha_compositor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_src_lightness,
    input  logic [15:0] i_src_chroma_a,
    input  logic [15:0] i_src_chroma_b,
    input  logic [15:0] i_src_alpha,
    input  logic [15:0] i_dst_lightness,
    input  logic [15:0] i_dst_chroma_a,
    input  logic [15:0] i_dst_chroma_b,
    input  logic [15:0] i_dst_alpha,
    input  logic [7:0]  i_mask_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_out_lightness,
    output logic [15:0] o_out_chroma_a,
    output logic [15:0] o_out_chroma_b,
    output logic [15:0] o_out_alpha
);

    lac_pkg::t_cfg  r_cfg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    lac_pkg::t_pix  w_src, w_dst, w_out;
    lac_pkg::t_item w_alpha_item, w_div_item;
    logic [15:0]    w_quo;
    logic           w_alpha_valid, w_alpha_ready;
    logic           w_div_valid, w_div_ready;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.blend_mode    <= lac_pkg::RST_BLEND_MODE;
            r_cfg.layer_opacity <= lac_pkg::RST_LAYER_OPACITY;
            r_cfg.mask_enable   <= lac_pkg::RST_MASK_ENABLE;
        end else if (wr_en) begin
            case (reg_idx)
                lac_pkg::REG_BLEND_MODE:    r_cfg.blend_mode    <= pwdata[1:0];
                lac_pkg::REG_LAYER_OPACITY: r_cfg.layer_opacity <= pwdata[7:0];
                lac_pkg::REG_MASK_ENABLE:   r_cfg.mask_enable   <= pwdata[0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            lac_pkg::REG_BLEND_MODE:    prdata = {30'h0, r_cfg.blend_mode};
            lac_pkg::REG_LAYER_OPACITY: prdata = {24'h0, r_cfg.layer_opacity};
            lac_pkg::REG_MASK_ENABLE:   prdata = {31'h0, r_cfg.mask_enable};
            default:                    prdata = 32'h0;
        endcase
    end

    assign w_src = '{lightness: i_src_lightness, chroma_a: i_src_chroma_a,
                     chroma_b: i_src_chroma_b, alpha: i_src_alpha};
    assign w_dst = '{lightness: i_dst_lightness, chroma_a: i_dst_chroma_a,
                     chroma_b: i_dst_chroma_b, alpha: i_dst_alpha};

    lac_alpha u_alpha (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_src   (w_src),
        .i_dst   (w_dst),
        .i_mask  (i_mask_value),
        .o_valid (w_alpha_valid),
        .i_ready (w_alpha_ready),
        .o_item  (w_alpha_item)
    );

    lac_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_alpha_valid),
        .o_ready (w_alpha_ready),
        .i_item  (w_alpha_item),
        .o_valid (w_div_valid),
        .i_ready (w_div_ready),
        .o_item  (w_div_item),
        .o_quo   (w_quo)
    );

    lac_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_div_valid),
        .o_ready (w_div_ready),
        .i_item  (w_div_item),
        .i_quo   (w_quo),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_pix   (w_out)
    );

    assign o_out_lightness = w_out.lightness;
    assign o_out_chroma_a  = w_out.chroma_a;
    assign o_out_chroma_b  = w_out.chroma_b;
    assign o_out_alpha     = w_out.alpha;

    // An empty output slot frees every stage, so the input must be open
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled while the output register is empty");

    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result presented right after reset");

endmodule

>>> dv/lab_alpha_compositor_test.sv
// Self-checking testbench for the Lab alpha compositor: directed and random pixels.
`timescale 1ns / 1ps

module lab_alpha_compositor_test;

    localparam logic [1:0] MODE_SPARE = 2'd3;   // unused code, behaves as pass
    localparam int STALL_PCT = 11;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;

    class pixel_scoreboard;
        lac_pkg::t_pix expected_pixels[$];
        logic [1:0]    blend_mode;
        logic [7:0]    opacity;
        logic          mask_on;
        int            mismatches;

        function new();
            blend_mode = lac_pkg::RST_BLEND_MODE;
            opacity    = lac_pkg::RST_LAYER_OPACITY;
            mask_on    = lac_pkg::RST_MASK_ENABLE;
            mismatches = 0;
        endfunction

        // Rounded 16x16 product scaled back to 16 bits
        function automatic logic [15:0] prod16(logic [15:0] x, logic [15:0] y);
            logic [63:0] t;
            t = 64'(x) * 64'(y) + 64'd32768;
            return 16'(((t >> 16) + t) >> 16);
        endfunction

        // y + floor((x - y) * f / 65536)
        function automatic logic [15:0] mix16(logic [15:0] x, logic [15:0] y,
                                              logic [15:0] f);
            longint dx, dy, df;
            dx = x;
            dy = y;
            df = f;
            return 16'((((dx - dy) * df) >>> 16) + dy);
        endfunction

        function automatic lac_pkg::t_pix composite_pixel(lac_pkg::t_pix s,
                                                          lac_pkg::t_pix d,
                                                          logic [7:0] mask);
            lac_pkg::t_pix o;
            logic [15:0]   sa, na, f;
            logic [63:0]   q;
            o  = d;
            sa = s.alpha;
            case (blend_mode)
                lac_pkg::MODE_OVER: begin
                    if (mask_on && mask != lac_pkg::MASK_FULL)
                        sa = prod16(sa, {mask, mask});
                    if (sa != 16'h0) begin
                        if (opacity != 8'hFF)
                            sa = prod16(sa, {opacity, opacity});
                        if (sa == lac_pkg::ALPHA_MAX) begin
                            o = s;
                        end else begin
                            if (d.alpha == lac_pkg::ALPHA_MAX) begin
                                f = sa;
                            end else begin
                                na = d.alpha + prod16(lac_pkg::ALPHA_MAX - d.alpha, sa);
                                o.alpha = na;
                                if (na == 16'h0) begin
                                    f = sa;
                                end else begin
                                    q = (64'(sa) * 64'd65535 + 64'(na >> 1)) / 64'(na);
                                    f = (q > 64'd65535) ? lac_pkg::ALPHA_MAX : q[15:0];
                                end
                            end
                            if (f == lac_pkg::ALPHA_MAX) begin
                                o = s;
                            end else begin
                                o.lightness = mix16(s.lightness, d.lightness, f);
                                o.chroma_a  = mix16(s.chroma_a, d.chroma_a, f);
                                o.chroma_b  = mix16(s.chroma_b, d.chroma_b, f);
                            end
                        end
                    end
                end
                lac_pkg::MODE_ERASE: begin
                    if (mask_on && mask != lac_pkg::MASK_FULL)
                        sa = mix16(sa, lac_pkg::ALPHA_MAX, {mask, mask});
                    o.alpha = prod16(sa, d.alpha);
                end
                default: ;
            endcase
            return o;
        endfunction

        function void take_pixel(lac_pkg::t_pix src, lac_pkg::t_pix dst,
                                  logic [7:0] mask);
            expected_pixels.insert(expected_pixels.size(),
                                   composite_pixel(src, dst, mask));
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        task report(string what);
            $display("%0t ns: mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(lac_pkg::t_pix got);
            lac_pkg::t_pix want;
            if (expected_pixels.size() == 0) begin
                report($sformatf("result %h with no pixel pending", got));
            end else begin
                want = expected_pixels.pop_front();
                if (got.lightness !== want.lightness)
                    report($sformatf("lightness got %h want %h", got.lightness,
                                     want.lightness));
                if (got.chroma_a !== want.chroma_a)
                    report($sformatf("chroma_a got %h want %h", got.chroma_a,
                                     want.chroma_a));
                if (got.chroma_b !== want.chroma_b)
                    report($sformatf("chroma_b got %h want %h", got.chroma_b,
                                     want.chroma_b));
                if (got.alpha !== want.alpha)
                    report($sformatf("alpha got %h want %h", got.alpha, want.alpha));
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [15:0] i_src_lightness = '0;
    logic [15:0] i_src_chroma_a = '0;
    logic [15:0] i_src_chroma_b = '0;
    logic [15:0] i_src_alpha = '0;
    logic [15:0] i_dst_lightness = '0;
    logic [15:0] i_dst_chroma_a = '0;
    logic [15:0] i_dst_chroma_b = '0;
    logic [15:0] i_dst_alpha = '0;
    logic [7:0]  i_mask_value = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_out_lightness;
    logic [15:0] o_out_chroma_a;
    logic [15:0] o_out_chroma_b;
    logic [15:0] o_out_alpha;

    pixel_scoreboard sb = new();
    bit              no_gaps = 1'b0;
    int              quiet_cycles = 0;

    lab_alpha_compositor DUT (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_ready <= no_gaps || ($urandom_range(0, 99) >= STALL_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.take_pixel({i_src_lightness, i_src_chroma_a, i_src_chroma_b, i_src_alpha},
                              {i_dst_lightness, i_dst_chroma_a, i_dst_chroma_b, i_dst_alpha},
                              i_mask_value);
            if (o_valid && i_ready)
                sb.check_result({o_out_lightness, o_out_chroma_a, o_out_chroma_b,
                                 o_out_alpha});
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_pixel(input lac_pkg::t_pix src, input lac_pkg::t_pix dst,
                              input logic [7:0] mask);
        while (!no_gaps && $urandom_range(0, 99) < STALL_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_src_lightness <= src.lightness;
        i_src_chroma_a  <= src.chroma_a;
        i_src_chroma_b  <= src.chroma_b;
        i_src_alpha     <= src.alpha;
        i_dst_lightness <= dst.lightness;
        i_dst_chroma_a  <= dst.chroma_a;
        i_dst_chroma_b  <= dst.chroma_b;
        i_dst_alpha     <= dst.alpha;
        i_mask_value    <= mask;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Hold input low and wait until every pending pixel has come back
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [1:0] mode, input logic [7:0] opac,
                              input logic mask_on);
        drain();
        write_reg(lac_pkg::REG_BLEND_MODE, 32'(mode));
        write_reg(lac_pkg::REG_LAYER_OPACITY, 32'(opac));
        write_reg(lac_pkg::REG_MASK_ENABLE, 32'(mask_on));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.blend_mode = mode;
        sb.opacity    = opac;
        sb.mask_on    = mask_on;
    endtask

    // Bias alpha toward the edges where the compositing rules change
    function automatic logic [15:0] pick_alpha();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return lac_pkg::ALPHA_MAX;
            2: return 16'(lac_pkg::ALPHA_MAX - $urandom_range(1, 3));
            3: return 16'($urandom_range(1, 4));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_mask();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return lac_pkg::MASK_FULL;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic run_random(input int count);
        lac_pkg::t_pix src, dst;
        for (int n = 0; n < count; n++) begin
            src = {16'($urandom), 16'($urandom), 16'($urandom), pick_alpha()};
            dst = {16'($urandom), 16'($urandom), 16'($urandom), pick_alpha()};
            send_pixel(src, dst, pick_mask());
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: over, full opacity, mask ignored
        send_pixel(64'hFFFF_FFFF_FFFF_0000, 64'h1234_5678_9ABC_DEF0, 8'h00);
        send_pixel(64'h1111_2222_3333_FFFF, 64'hAAAA_BBBB_CCCC_4000, 8'h00);
        send_pixel(64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000, 8'h00);
        send_pixel(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
        send_pixel(64'h8000_0100_FF00_8000, 64'h0200_7000_0010_FFFF, 8'h00);
        send_pixel(64'hFFFF_FFFF_FFFF_0001, 64'h0000_0000_0000_0000, 8'h00);
        send_pixel(64'h0000_0000_0000_7FFF, 64'hFFFF_FFFF_FFFF_4000, 8'h55);
        send_pixel(64'hFFFF_FFFF_FFFF_C000, 64'h0000_0000_0000_8000, 8'hAA);

        set_config(lac_pkg::MODE_OVER, 8'hFF, 1'b1);
        send_pixel(64'h4000_C000_2000_8000, 64'hC000_4000_E000_2000, lac_pkg::MASK_FULL);
        send_pixel(64'h4000_C000_2000_FFFF, 64'hC000_4000_E000_2000, 8'h00);
        send_pixel(64'h4000_C000_2000_FFFF, 64'hC000_4000_E000_2000, 8'h80);

        // Zero opacity drives the scaled alpha to zero after the mask step
        set_config(lac_pkg::MODE_OVER, 8'h00, 1'b1);
        send_pixel(64'hFFFF_0000_FFFF_8000, 64'h0000_FFFF_0000_0000, lac_pkg::MASK_FULL);
        send_pixel(64'hFFFF_0000_FFFF_8000, 64'h0000_FFFF_0000_FFFF, lac_pkg::MASK_FULL);

        set_config(lac_pkg::MODE_OVER, 8'h80, 1'b0);
        send_pixel(64'h9999_6666_3333_FFFF, 64'h1111_2222_3333_1234, 8'h00);

        set_config(lac_pkg::MODE_ERASE, 8'hFF, 1'b1);
        send_pixel(64'h1234_5678_9ABC_4000, 64'hFFFF_0000_FFFF_C000, 8'h00);
        send_pixel(64'h1234_5678_9ABC_4000, 64'hFFFF_0000_FFFF_C000, lac_pkg::MASK_FULL);
        send_pixel(64'h1234_5678_9ABC_0000, 64'hFFFF_0000_FFFF_FFFF, 8'h40);

        set_config(lac_pkg::MODE_PASS, 8'h10, 1'b1);
        send_pixel(64'hFFFF_FFFF_FFFF_FFFF, 64'h0102_0304_0506_0708, 8'h00);
        set_config(MODE_SPARE, 8'hFF, 1'b0);
        send_pixel(64'hFFFF_FFFF_FFFF_FFFF, 64'h0807_0605_0403_0201, 8'h00);

        set_config(lac_pkg::MODE_OVER, 8'hFF, 1'b0);
        no_gaps = 1'b1;
        run_random(150);
        no_gaps = 1'b0;
        set_config(lac_pkg::MODE_OVER, 8'hFF, 1'b1);
        run_random(75);
        drain();
        run_random(75);
        set_config(lac_pkg::MODE_OVER, 8'h00, 1'b1);
        run_random(80);
        set_config(lac_pkg::MODE_OVER, 8'($urandom_range(1, 254)), 1'b1);
        run_random(150);
        set_config(lac_pkg::MODE_OVER, 8'($urandom_range(1, 254)), 1'b0);
        run_random(150);
        set_config(lac_pkg::MODE_OVER, 8'h01, 1'b1);
        run_random(80);
        set_config(lac_pkg::MODE_ERASE, 8'hFF, 1'b1);
        run_random(120);
        set_config(lac_pkg::MODE_ERASE, 8'($urandom), 1'b0);
        run_random(80);
        set_config(lac_pkg::MODE_PASS, 8'($urandom), 1'b1);
        run_random(60);
        set_config(MODE_SPARE, 8'($urandom), 1'b1);
        run_random(60);
        set_config(lac_pkg::MODE_OVER, 8'hFE, 1'b1);
        run_random(150);

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> lab_alpha_compositor.f
design/lac_pkg.sv
design/lac_alpha.sv
design/lac_div.sv
design/lac_blend.sv
design/lab_alpha_compositor.sv
dv/lab_alpha_compositor_test.sv
